/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define SVS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("svs assertion failed");

// Clocked assertion that also holds during reset
`define SVS_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("svs assertion failed (reset)");

`endif

/* rtl/core/svs_pkg.sv */
// Package for the scanline/vignette shader: fixed-point constants, item types, CSR codes.
// No dependencies; used by every module of the block.
`default_nettype none

package svs_pkg;

   // field widths
   localparam int COORD_X_W = 9;
   localparam int COORD_Y_W = 8;
   localparam int PIXEL_W   = 32;
   localparam int CHAN_W    = 8;

   // unsigned Q2.16 factors
   localparam int FX_W = 18;
   localparam logic [FX_W-1:0] FX_ONE      = 18'd65536;
   localparam logic [FX_W-1:0] FX_MAX      = 18'h3FFFF;
   localparam logic [FX_W-1:0] FX_SCAN     = 18'd53740;
   localparam logic [FX_W-1:0] FX_THRESH   = 18'd39322;
   localparam logic [14:0]     FX_SLOPE    = 15'd22938;
   localparam logic [FX_W-1:0] FX_NEAR_ONE = 18'd65470;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // reciprocal width used by the distance divider
   localparam int RECIP_W = 20;

   // decoupling queue and back-end depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;
   localparam int BACK_STAGES = 9;

   // configuration register indexes
   typedef enum logic {
      CSR_SCANLINE_ENABLE = 1'b0,
      CSR_VIGNETTE_ENABLE = 1'b1
   } csr_index_type;

   // item as classified by the front end
   typedef struct packed {
      logic [COORD_X_W-1:0] x;
      logic [COORD_Y_W-1:0] y;
      logic [PIXEL_W-1:0]   pixel;
      logic                 scan_on;
      logic                 vig_on;
      logic                 any_on;
   } svs_item_type;

   // what travels alongside the arithmetic in the back end
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               scan_on;
      logic               vig_on;
      logic               any_on;
   } svs_tag_type;

endpackage

`default_nettype wire

/* rtl/core/svs_front.sv */
// Front end: holds the two enable registers and classifies each incoming request.
// Depends on svs_pkg.
`default_nettype none

module svs_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire svs_pkg::csr_index_type        csr_index,
   input  wire logic                          csr_wdata,
   input  wire logic [svs_pkg::COORD_X_W-1:0] pixel_x,
   input  wire logic [svs_pkg::COORD_Y_W-1:0] pixel_y,
   input  wire logic [svs_pkg::PIXEL_W-1:0]   pixel_in,
   output svs_pkg::svs_item_type              item
);

   logic scan_en_ff, scan_en_in;
   logic vig_en_ff, vig_en_in;

   // register writes
   always_comb begin
      scan_en_in = scan_en_ff;
      vig_en_in  = vig_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            svs_pkg::CSR_SCANLINE_ENABLE: scan_en_in = csr_wdata;
            svs_pkg::CSR_VIGNETTE_ENABLE: vig_en_in  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_en_ff <= 1'b0;
         vig_en_ff  <= 1'b0;
      end else begin
         scan_en_ff <= scan_en_in;
         vig_en_ff  <= vig_en_in;
      end
   end

   // classification: odd row darkening, vignette, or plain pass
   always_comb begin
      item.x       = pixel_x;
      item.y       = pixel_y;
      item.pixel   = pixel_in;
      item.scan_on = scan_en_ff & pixel_y[0];
      item.vig_on  = vig_en_ff;
      item.any_on  = scan_en_ff | vig_en_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/svs_queue.sv */
// Short register queue between the front end and the back end.
// Depends on svs_pkg.
`default_nettype none

module svs_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire svs_pkg::svs_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       not_empty,
   output svs_pkg::svs_item_type      head_item
);

   svs_pkg::svs_item_type mem_ff [svs_pkg::QUEUE_DEPTH];

   logic [svs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [svs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [svs_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == svs_pkg::QUEUE_CNT_W'(svs_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      priority case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/svs_norm.sv */
// Normalised offset |2p - size| * 65536 / size in Q2.16, saturated, four stages.
// Division by the constant size is a reciprocal multiply plus one correction step.
// Depends on svs_pkg.
`default_nettype none

module svs_norm #(
   parameter int SIZE    = 320,
   parameter int COORD_W = 9
) (
   input  wire logic                       clock,
   input  wire logic                       adv,
   input  wire logic [COORD_W-1:0]         coord,
   output logic [svs_pkg::FX_W-1:0]        offset
);

   localparam int TWICE_MAX = 2 * ((1 << COORD_W) - 1);
   localparam int MAG_MAX   = (TWICE_MAX > SIZE) ? TWICE_MAX : SIZE;
   localparam int MAG_W     = $clog2(MAG_MAX + 1);
   localparam int SIZE_W    = $clog2(SIZE + 1);
   localparam int RECIP_K   = $clog2(SIZE) + 18;
   localparam int SHIFT     = RECIP_K - 16;
   localparam int PROD_W    = MAG_W + svs_pkg::RECIP_W;
   localparam int QW_W      = svs_pkg::FX_W + SIZE_W;
   localparam int NUM_W     = MAG_W + 16;
   localparam int REM_W     = ((NUM_W > QW_W) ? NUM_W : QW_W) + 1;
   localparam logic [svs_pkg::RECIP_W-1:0] RECIP =
      svs_pkg::RECIP_W'((64'd1 << RECIP_K) / SIZE);

   logic [MAG_W-1:0]          mag1_ff, mag1_in, mag2_ff, mag3_ff;
   logic                      sat1_ff, sat1_in, sat2_ff, sat3_ff;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [svs_pkg::FX_W-1:0]  q0_ff, q0_in;
   logic [QW_W-1:0]           qw_ff, qw_in;
   logic [svs_pkg::FX_W-1:0]  dist_ff, dist_in;
   logic [MAG_W-1:0]          twice;
   logic [REM_W-1:0]          rem;

   // stage 1: magnitude of the offset and the saturation test (q >= 4.0)
   always_comb begin
      twice   = MAG_W'({coord, 1'b0});
      mag1_in = (twice >= MAG_W'(SIZE)) ? twice - MAG_W'(SIZE) : MAG_W'(SIZE) - twice;
      sat1_in = ((MAG_W + 3)'(mag1_in) >= (MAG_W + 3)'(4 * SIZE));
   end

   // stage 2: multiply by the truncated reciprocal
   assign prod_in = PROD_W'(mag1_ff) * PROD_W'(RECIP);

   // stage 3: estimate is exact or one low; form estimate * size
   always_comb begin
      q0_in = prod_ff[SHIFT +: svs_pkg::FX_W];
      qw_in = QW_W'(q0_in) * QW_W'(SIZE);
   end

   // stage 4: correct the estimate by the remainder
   always_comb begin
      rem = REM_W'({mag3_ff, 16'h0000}) - REM_W'(qw_ff);
      if (sat3_ff) begin
         dist_in = svs_pkg::FX_MAX;
      end else if (rem >= REM_W'(SIZE)) begin
         dist_in = q0_ff + 1'b1;
      end else begin
         dist_in = q0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag1_ff <= mag1_in;
         sat1_ff <= sat1_in;
         prod_ff <= prod_in;
         mag2_ff <= mag1_ff;
         sat2_ff <= sat1_ff;
         q0_ff   <= q0_in;
         qw_ff   <= qw_in;
         mag3_ff <= mag2_ff;
         sat3_ff <= sat2_ff;
         dist_ff <= dist_in;
      end
   end

   assign offset = dist_ff;

endmodule

`default_nettype wire

/* rtl/core/svs_back.sv */
// Back end: nine-stage pipeline from queue head to the result register.
// Depends on svs_pkg and svs_norm.
`default_nettype none

module svs_back #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         head_valid,
   input  wire svs_pkg::svs_item_type        head_item,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [svs_pkg::PIXEL_W-1:0]       pixel_out
);

   localparam int NS = svs_pkg::BACK_STAGES;

   logic                      adv;
   logic [NS-1:0]             valid_ff, valid_in;
   svs_pkg::svs_tag_type      tag_ff [NS-1];
   svs_pkg::svs_tag_type      head_tag;

   logic [svs_pkg::FX_W-1:0]  dx, dy;
   logic [2*svs_pkg::FX_W-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [svs_pkg::FX_W+2:0]  dsum;
   logic [svs_pkg::FX_W-1:0]  dist_sq;
   logic                      over_ff, over_in;
   logic [32:0]               excess_ff, excess_in;
   logic [16:0]               drop;
   logic [svs_pkg::FX_W-1:0]  vig, scan;
   logic [2*svs_pkg::FX_W-1:0] fac_ff, fac_in;
   logic [svs_pkg::FX_W-1:0]  mult;
   logic                      dark_ff, dark_in;
   logic [25:0]               red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [svs_pkg::PIXEL_W-1:0] out_ff, out_in;

   // whole pipeline moves when the result register is free or being taken
   assign adv      = !valid_ff[NS-1] || rsp_tready;
   assign pop      = adv && head_valid;
   assign valid_in = {valid_ff[NS-2:0], head_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // side-band travelling with the item
   always_comb begin
      head_tag.pixel   = head_item.pixel;
      head_tag.scan_on = head_item.scan_on;
      head_tag.vig_on  = head_item.vig_on;
      head_tag.any_on  = head_item.any_on;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= head_tag;
         for (int i = 1; i < NS - 1; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   // stages 1 to 4: normalised offsets
   svs_norm #(
      .SIZE    (SCREEN_W),
      .COORD_W (svs_pkg::COORD_X_W)
   ) u_norm_x (
      .clock  (clock),
      .adv    (adv),
      .coord  (head_item.x),
      .offset (dx)
   );

   svs_norm #(
      .SIZE    (SCREEN_H),
      .COORD_W (svs_pkg::COORD_Y_W)
   ) u_norm_y (
      .clock  (clock),
      .adv    (adv),
      .coord  (head_item.y),
      .offset (dy)
   );

   // stage 5: squares
   always_comb begin
      sqx_in = (2*svs_pkg::FX_W)'(dx) * (2*svs_pkg::FX_W)'(dx);
      sqy_in = (2*svs_pkg::FX_W)'(dy) * (2*svs_pkg::FX_W)'(dy);
   end

   // stage 6: distance sum, saturation, threshold and slope product
   always_comb begin
      dsum = (svs_pkg::FX_W + 3)'(sqx_ff[2*svs_pkg::FX_W-1:16])
           + (svs_pkg::FX_W + 3)'(sqy_ff[2*svs_pkg::FX_W-1:16]);
      dist_sq = (dsum > (svs_pkg::FX_W + 3)'(svs_pkg::FX_MAX)) ?
                svs_pkg::FX_MAX : dsum[svs_pkg::FX_W-1:0];
      over_in   = (dist_sq > svs_pkg::FX_THRESH);
      excess_in = 33'(dist_sq - svs_pkg::FX_THRESH) * 33'(svs_pkg::FX_SLOPE);
   end

   // stage 7: vignette factor times scan-line factor
   always_comb begin
      drop = excess_ff[32:16];
      if (!tag_ff[5].vig_on || !over_ff) begin
         vig = svs_pkg::FX_ONE;
      end else if (svs_pkg::FX_W'(drop) >= svs_pkg::FX_ONE) begin
         vig = '0;
      end else begin
         vig = svs_pkg::FX_ONE - svs_pkg::FX_W'(drop);
      end
      scan   = tag_ff[5].scan_on ? svs_pkg::FX_SCAN : svs_pkg::FX_ONE;
      fac_in = (2*svs_pkg::FX_W)'(scan) * (2*svs_pkg::FX_W)'(vig);
   end

   // stage 8: darken decision and channel products
   always_comb begin
      mult     = fac_ff[16 +: svs_pkg::FX_W];
      dark_in  = tag_ff[6].any_on && (mult < svs_pkg::FX_NEAR_ONE);
      red_in   = 26'(tag_ff[6].pixel[23:16]) * 26'(mult);
      green_in = 26'(tag_ff[6].pixel[15:8])  * 26'(mult);
      blue_in  = 26'(tag_ff[6].pixel[7:0])   * 26'(mult);
   end

   // stage 9: result register
   always_comb begin
      if (dark_ff) begin
         out_in = {svs_pkg::ALPHA_OPAQUE, red_ff[23:16], green_ff[23:16], blue_ff[23:16]};
      end else begin
         out_in = tag_ff[7].pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
         over_ff   <= over_in;
         excess_ff <= excess_in;
         fac_ff    <= fac_in;
         dark_ff   <= dark_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_tvalid = valid_ff[NS-1];
   assign pixel_out  = out_ff;

endmodule

`default_nettype wire

/* rtl/core/scanline_vignette_shader_unit.sv */
// Top level of the scanline/vignette pixel shader: front end, queue, back-end pipeline.
// Depends on svs_pkg, svs_front, svs_queue, svs_back (and svs_norm below it).
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | req_tdata: pixel_x, pixel_y, pixel_in
//   rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: pixel_out
//   csr     | in  | csr_wr_en             | csr_index, csr_wdata
//
// One pixel per cycle sustained while rsp_tready stays high; an accepted pixel is written
// into the queue, then runs through the nine-stage back end (divider, squares, factors).
// A four-entry queue sits between the front end and the back end; req_tready drops
// only when that queue is full. A stalled rsp freezes the back end, which then fills
// the queue. Reset is synchronous and clears enables, queue and valid bits.
`default_nettype none

module scanline_vignette_shader_unit #(
   parameter int SCREEN_W = 320,
   parameter int SCREEN_H = 240
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [55:0]   req_tdata,   // pixel_x[8:0], pixel_y[16:9], pixel_in[48:17], zero
   // result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // pixel_out[31:0]
   // configuration
   input  wire logic          csr_wr_en,
   input  wire logic          csr_index,
   input  wire logic          csr_wdata
);

   svs_pkg::svs_item_type item;
   svs_pkg::svs_item_type head_item;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  pop;
   logic                  push;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   svs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (svs_pkg::csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .pixel_x   (req_tdata[8:0]),
      .pixel_y   (req_tdata[16:9]),
      .pixel_in  (req_tdata[48:17]),
      .item      (item)
   );

   svs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   svs_back #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_out  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/svs_checker.sv */
// Port-level checker for the shader unit, bound to the top level below.
// Depends on svs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module svs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   localparam int CAPACITY = svs_pkg::QUEUE_DEPTH + svs_pkg::BACK_STAGES;

   logic [4:0] count_ff, count_in;
   logic       req_acc, rsp_acc;

   // requests in flight, seen from the ports
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      priority case ({req_acc, rsp_acc})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a stalled result holds
   `SVS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // reset empties the pipeline
   `SVS_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)
   // no result without an outstanding request
   `SVS_ASSERT(a_no_invent, clock, reset, rsp_tvalid |-> count_ff != 5'd0)
   // with every slot taken the block stops accepting
   `SVS_ASSERT(a_full_block, clock, reset, count_ff == 5'(CAPACITY) |-> !req_tready)

endmodule

bind scanline_vignette_shader_unit svs_checker u_checker (.*);

`default_nettype wire

/* bench/tb_scanline_vignette_shader_unit.sv */
// Self-checking bench for scanline_vignette_shader_unit: drives pixel requests and CSR writes,
// predicts each shaded pixel in fixed point and compares it with the result stream.
// Depends on svs_pkg and the RTL of the block only.
module tb_scanline_vignette_shader_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCREEN_W       = 320;
   localparam int SCREEN_H       = 240;
   localparam int RESET_CYCLES   = 10;
   localparam int DRAIN_SETTLE   = 3;
   localparam int TAIL_CYCLES    = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_PIXELS   = 180;

   typedef enum logic [1:0] {
      JOB_PIXEL,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   // one entry of the request schedule
   typedef struct {
      job_kind_type           kind;
      logic [8:0]             x;
      logic [7:0]             y;
      logic [31:0]            pixel;
      int                     gap;
      svs_pkg::csr_index_type csr_reg;
      logic                   csr_val;
   } pixel_job_type;

   // shaded pixel awaited on the result channel, with the pixel it came from
   typedef struct {
      logic [31:0] shaded;
      logic [31:0] original;
   } shade_expect_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata  = '0;   // pixel_x[8:0], pixel_y[16:9], pixel_in[48:17], zero
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;         // pixel_out[31:0]
   logic          csr_wr_en  = 1'b0;
   logic          csr_index  = 1'b0;
   logic          csr_wdata  = 1'b0;

   pixel_job_type    job_q[$];
   shade_expect_type shaded_q[$];

   // predictor copy of the enable registers
   logic scan_cfg = 1'b0;
   logic vig_cfg  = 1'b0;

   int gap_left       = 0;
   int settle_left    = 0;
   int stall_left     = 0;
   int mode_left      = 0;
   bit choppy_rx      = 1'b0;
   int idle_cycles    = 0;
   int mismatches     = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int darkened_seen  = 0;
   int settings_seen  = 0;

   scanline_vignette_shader_unit #(
      .SCREEN_W (SCREEN_W),
      .SCREEN_H (SCREEN_H)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // |2p - span| / span in Q2.16, saturated
   function automatic logic [63:0] centre_offset(input logic [63:0] p, input logic [63:0] span);
      logic [63:0] twice;
      logic [63:0] mag;
      logic [63:0] q;
      twice = 2 * p;
      mag   = (twice >= span) ? twice - span : span - twice;
      q     = (mag << 16) / span;
      return (q > svs_pkg::FX_MAX) ? 64'(svs_pkg::FX_MAX) : q;
   endfunction

   function automatic logic [63:0] vignette_gain(input logic [8:0] x, input logic [7:0] y);
      logic [63:0] dx;
      logic [63:0] dy;
      logic [63:0] d_sq;
      logic [63:0] drop;
      dx   = centre_offset(64'(x), 64'(SCREEN_W));
      dy   = centre_offset(64'(y), 64'(SCREEN_H));
      d_sq = ((dx * dx) >> 16) + ((dy * dy) >> 16);
      if (d_sq > svs_pkg::FX_MAX) d_sq = 64'(svs_pkg::FX_MAX);
      if (d_sq <= svs_pkg::FX_THRESH) return 64'(svs_pkg::FX_ONE);
      drop = ((d_sq - svs_pkg::FX_THRESH) * svs_pkg::FX_SLOPE) >> 16;
      return (drop >= svs_pkg::FX_ONE) ? 64'd0 : 64'(svs_pkg::FX_ONE) - drop;
   endfunction

   function automatic logic [31:0] shade_pixel(input logic [8:0] x, input logic [7:0] y,
                                               input logic [31:0] pix,
                                               input logic scan_en, input logic vig_en);
      logic [63:0] scan_f;
      logic [63:0] vig_f;
      logic [63:0] mult;
      logic [63:0] r;
      logic [63:0] g;
      logic [63:0] b;
      scan_f = 64'(svs_pkg::FX_ONE);
      vig_f  = 64'(svs_pkg::FX_ONE);
      if (scan_en && y[0]) scan_f = 64'(svs_pkg::FX_SCAN);
      if (vig_en) vig_f = vignette_gain(x, y);
      mult = (scan_f * vig_f) >> 16;
      // factor close enough to one leaves the pixel, alpha included, untouched
      if (!(scan_en || vig_en) || mult >= svs_pkg::FX_NEAR_ONE) return pix;
      r = (64'(pix[23:16]) * mult) >> 16;
      g = (64'(pix[15:8]) * mult) >> 16;
      b = (64'(pix[7:0]) * mult) >> 16;
      return {svs_pkg::ALPHA_OPAQUE, r[7:0], g[7:0], b[7:0]};
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_mismatch(input string msg);
      $display("[%0t] ERROR %s", $realtime, msg);
      mismatches++;
   endtask

   // sender gaps: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_stall();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 80);
   endfunction

   task automatic add_pixel(input logic [8:0] x, input logic [7:0] y, input logic [31:0] pix,
                            input int gap);
      pixel_job_type j;
      j = '{kind: JOB_PIXEL, x: x, y: y, pixel: pix, gap: gap,
            csr_reg: svs_pkg::CSR_SCANLINE_ENABLE, csr_val: 1'b0};
      job_q.push_back(j);
   endtask

   // wait for the pipeline to empty, then write both enables
   task automatic add_setting(input logic scan_en, input logic vig_en);
      pixel_job_type j;
      j = '{kind: JOB_DRAIN, x: '0, y: '0, pixel: '0, gap: 0,
            csr_reg: svs_pkg::CSR_SCANLINE_ENABLE, csr_val: 1'b0};
      job_q.push_back(j);
      j.kind    = JOB_CSR;
      j.csr_reg = svs_pkg::CSR_SCANLINE_ENABLE;
      j.csr_val = scan_en;
      job_q.push_back(j);
      j.csr_reg = svs_pkg::CSR_VIGNETTE_ENABLE;
      j.csr_val = vig_en;
      job_q.push_back(j);
   endtask

   task automatic add_drain();
      pixel_job_type j;
      j = '{kind: JOB_DRAIN, x: '0, y: '0, pixel: '0, gap: 0,
            csr_reg: svs_pkg::CSR_SCANLINE_ENABLE, csr_val: 1'b0};
      job_q.push_back(j);
   endtask

   // mostly on-screen pixels, some on the borders and centre lines, some off-screen
   task automatic add_random_pixel(input bit quiet);
      logic [8:0]  x;
      logic [7:0]  y;
      logic [31:0] pix;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         x = 9'($urandom_range(0, SCREEN_W - 1));
         y = 8'($urandom_range(0, SCREEN_H - 1));
      end else if (r < 85) begin
         case ($urandom_range(0, 3))
            0: x = 9'd0;
            1: x = 9'(SCREEN_W - 1);
            2: x = 9'(SCREEN_W / 2);
            default: x = 9'($urandom_range(0, SCREEN_W - 1));
         endcase
         case ($urandom_range(0, 3))
            0: y = 8'd0;
            1: y = 8'(SCREEN_H - 1);
            2: y = 8'(SCREEN_H / 2);
            default: y = 8'($urandom_range(0, SCREEN_H - 1));
         endcase
      end else begin
         x = 9'($urandom_range(0, 511));
         y = 8'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 85)      pix = $urandom;
      else if (r < 90) pix = 32'hFFFF_FFFF;
      else if (r < 94) pix = 32'h0000_0000;
      else if (r < 97) pix = 32'h00FF_FFFF;
      else             pix = 32'hFF00_0000;
      add_pixel(x, y, pix, quiet ? 0 : pick_gap());
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin : request_driver
      logic          drive_valid;
      logic          drive_wr;
      pixel_job_type job;
      drive_valid = req_tvalid;
      drive_wr    = 1'b0;
      if (reset) begin
         drive_valid = 1'b0;
         gap_left    = 0;
         settle_left = 0;
      end else begin
         // request taken: predict its result now, with the settings in force
         if (req_tvalid && req_tready) begin
            shaded_q.push_back('{shaded: shade_pixel(req_tdata[8:0], req_tdata[16:9],
                                                     req_tdata[48:17], scan_cfg, vig_cfg),
                                 original: req_tdata[48:17]});
            pixels_sent++;
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (job_q.size() != 0) begin
               job = job_q[0];
               case (job.kind)
                  JOB_PIXEL: begin
                     req_tdata  <= {7'd0, job.pixel, job.y, job.x};
                     drive_valid = 1'b1;
                     gap_left    = job.gap;
                     void'(job_q.pop_front());
                  end
                  JOB_CSR: begin
                     csr_index <= job.csr_reg;
                     csr_wdata <= job.csr_val;
                     drive_wr   = 1'b1;
                     if (job.csr_reg == svs_pkg::CSR_SCANLINE_ENABLE) scan_cfg = job.csr_val;
                     else                                             vig_cfg  = job.csr_val;
                     void'(job_q.pop_front());
                  end
                  default: begin
                     // hold off until every result is back and the settle counter reaches DRAIN_SETTLE
                     if (shaded_q.size() == 0) begin
                        if (settle_left >= DRAIN_SETTLE) begin
                           settle_left = 0;
                           void'(job_q.pop_front());
                        end else begin
                           settle_left++;
                        end
                     end
                  end
               endcase
            end
         end
      end
      req_tvalid <= drive_valid;
      csr_wr_en  <= drive_wr;
   end

   // ---------------------------------------------------------------- result monitor

   always @(posedge clock) begin : result_monitor
      shade_expect_type want;
      logic             ready_next;
      ready_next = 1'b1;
      if (reset) begin
         stall_left = 0;
         mode_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (shaded_q.size() == 0) begin
               report_mismatch($sformatf("result %h with no request outstanding", rsp_tdata));
            end else begin
               want = shaded_q.pop_front();
               results_seen++;
               if (want.shaded != want.original) darkened_seen++;
               if (rsp_tdata !== want.shaded)
                  report_mismatch($sformatf("result %0d pixel_out %h, expected %h (input %h)",
                                            results_seen, rsp_tdata, want.shaded,
                                            want.original));
            end
         end
         // back-pressure alternates between steady and choppy stretches
         if (mode_left == 0) begin
            choppy_rx = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(40, 300);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (choppy_rx && $urandom_range(0, 99) < 25) begin
            stall_left = pick_stall() - 1;
            ready_next = 1'b0;
         end
      end
      rsp_tready <= ready_next;
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] ERROR no traffic for %0d cycles", $realtime, idle_cycles);
         $display("scanline_vignette_shader_unit: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- schedule and end

   initial begin : stimulus
      logic scan_en;
      logic vig_en;
      bit   quiet;

      // reset values: both modes off, everything passes through
      add_pixel(9'd0,   8'd0,   32'h0000_0000, 0);
      add_pixel(9'd511, 8'd255, 32'hFFFF_FFFF, pick_gap());
      add_pixel(9'd319, 8'd239, 32'h1234_5678, 0);

      // scan lines only: even row untouched, odd row darkened
      add_setting(1'b1, 1'b0);
      add_pixel(9'd100, 8'd0,   32'hFFFF_FFFF, 0);
      add_pixel(9'd100, 8'd1,   32'hFFFF_FFFF, 0);
      add_pixel(9'd0,   8'd255, 32'h80FF_7F01, pick_gap());

      // vignette only: centre, corners, off-screen saturation down to black
      add_setting(1'b0, 1'b1);
      add_pixel(9'd160, 8'd120, 32'hFFFF_FFFF, 0);
      add_pixel(9'd0,   8'd0,   32'hFFFF_FFFF, 0);
      add_pixel(9'd319, 8'd239, 32'h00FF_FFFF, pick_gap());
      add_pixel(9'd511, 8'd0,   32'hAABB_CCDD, 0);
      add_pixel(9'd511, 8'd255, 32'hFFFF_FFFF, 0);
      add_pixel(9'd0,   8'd239, 32'h7F80_8182, 0);
      add_pixel(9'd320, 8'd240, 32'hFFFF_FFFF, pick_gap());

      // both on
      add_setting(1'b1, 1'b1);
      add_pixel(9'd0,   8'd1,   32'hFFFF_FFFF, 0);
      add_pixel(9'd160, 8'd121, 32'hFFFF_FFFF, 0);
      add_pixel(9'd160, 8'd120, 32'hFFFF_FFFF, 0);
      add_pixel(9'd511, 8'd255, 32'hFF00_FF00, pick_gap());
      add_pixel(9'd300, 8'd17,  32'h0102_0304, 0);

      // random phases: the first four walk every setting, the rest pick at random
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < 4) begin
            scan_en = ph[0];
            vig_en  = ph[1];
         end else begin
            scan_en = 1'($urandom_range(0, 1));
            vig_en  = 1'($urandom_range(0, 1));
         end
         quiet = (ph == 2 || ph == 6);
         add_setting(scan_en, vig_en);
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if (ph == 5 && i == PHASE_PIXELS / 2) add_drain();
            add_random_pixel(quiet);
         end
      end
      settings_seen = 4 + RANDOM_PHASES;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (job_q.size() != 0 || req_tvalid || shaded_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d pixels across %0d enable settings, %0d results checked",
               pixels_sent, settings_seen, results_seen);
      $display("%0d results darkened, %0d passed through unchanged",
               darkened_seen, results_seen - darkened_seen);
      if (mismatches == 0) begin
         $display("scanline_vignette_shader_unit: match");
      end else begin
         $display("scanline_vignette_shader_unit: mismatch");
      end
      $finish;
   end

endmodule
